>>> rtl/byte_ring_buffer_peek_consume_assert.svh
// Assertion macros used by the byte ring buffer checker.
`ifndef BYTE_RING_BUFFER_PEEK_CONSUME_ASSERT_SVH
`define BYTE_RING_BUFFER_PEEK_CONSUME_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/brb_pkg.sv
// Types and codes of the byte ring buffer.
`timescale 1ns / 1ps
package brb_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned OFS_W    = 12;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BCNT_W   = 4;
  localparam int unsigned FILL_W   = 13;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_PEEK    = 3'd2,
    OP_CONSUME = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_SHORT    = 2'd2,
    ST_BAD_LEN  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_WRITE,
    CS_GATHER,
    CS_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [LEN_W-1:0]  length;
    logic [OFS_W-1:0]  offset;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   read_data;
    logic [BCNT_W-1:0]   byte_count;
    logic                last;
    logic [FILL_W-1:0]   fill_count;
    logic [FILL_W-1:0]   free_space;
  } res_t;

endpackage

>>> rtl/brb_store.sv
// Byte-wide synchronous store, one write and one read port, registered read.
`timescale 1ns / 1ps
module brb_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/brb_ctrl.sv
// Request sequencer: decode, pointers, byte-serial store access, word assembly.
`timescale 1ns / 1ps
module brb_ctrl #(
  parameter int unsigned CAPACITY    = 4096,
  parameter int unsigned WORD_BYTES  = 8,
  parameter int unsigned MAX_REQUEST = 64,
  parameter int unsigned AW          = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  brb_pkg::req_t req_i,
  output logic          res_push_o,
  input  logic          res_ready_i,
  output brb_pkg::res_t res_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [7:0]    mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [7:0]    mem_rdata_i
);
  import brb_pkg::*;

  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned PW  = AW + 1;
  localparam int unsigned SW  = ((CW > FILL_W) ? CW : FILL_W) + 1;
  localparam int unsigned MAX_RD = (MAX_REQUEST < 8 * WORD_BYTES) ? MAX_REQUEST
                                                                   : 8 * WORD_BYTES;

  ctrl_state_e       state_q, state_d;
  logic [AW-1:0]     wp_q, wp_d, rp_q, rp_d, pos_q, pos_d;
  logic [CW-1:0]     held_q, held_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic [BCNT_W-1:0] n_q, n_d, iss_q, iss_d, cap_q, cap_d;
  logic              pend_q, pend_d;
  logic [2:0]        widx_q, widx_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] word_q, word_d, wdata_q, wdata_d;

  logic [SW-1:0]     len_x, held_x, free_x, peek_end;
  logic [PW-1:0]     rp_len, rp_ofs;
  logic [LEN_W-1:0]  left_next;
  logic [31:0]       fill32, free32;

  function automatic logic [AW-1:0] wrap_ptr(input logic [PW-1:0] s);
    logic [PW-1:0] r;
    r = (s >= PW'(CAPACITY)) ? s - PW'(CAPACITY) : s;
    return r[AW-1:0];
  endfunction

  function automatic logic [BCNT_W-1:0] word_len(input logic [LEN_W-1:0] l);
    return (l > LEN_W'(WORD_BYTES)) ? BCNT_W'(WORD_BYTES) : l[BCNT_W-1:0];
  endfunction

  assign len_x     = SW'(req_i.length);
  assign held_x    = SW'(held_q);
  assign free_x    = SW'(CAPACITY) - held_x;
  assign peek_end  = SW'(req_i.offset) + len_x;
  assign rp_len    = PW'(rp_q) + PW'(req_i.length);
  assign rp_ofs    = PW'(rp_q) + PW'(req_i.offset);
  assign left_next = left_q - LEN_W'(n_q);

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    pos_d       = pos_q;
    held_d      = held_q;
    left_d      = left_q;
    n_d         = n_q;
    iss_d       = iss_q;
    cap_d       = cap_q;
    widx_d      = widx_q;
    status_d    = status_q;
    word_d      = word_q;
    wdata_d     = wdata_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    res_push_o  = 1'b0;
    req_ready_o = 1'b0;

    unique case (state_q)
      CS_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          // default outcome: one empty, final result
          status_d = ST_OK;
          word_d   = '0;
          left_d   = '0;
          n_d      = '0;
          iss_d    = '0;
          cap_d    = '0;
          widx_d   = '0;
          wdata_d  = req_i.write_data;
          state_d  = CS_EMIT;
          if (op_e'(req_i.operation) == OP_CLEAR) begin
            wp_d   = '0;
            rp_d   = '0;
            held_d = '0;
          end else if (req_i.length != '0) begin
            unique case (op_e'(req_i.operation)) inside
              OP_WRITE: begin
                if (req_i.length > LEN_W'(WORD_BYTES)) begin
                  status_d = ST_BAD_LEN;
                end else if (len_x > free_x) begin
                  status_d = ST_OVERFLOW;
                end else begin
                  held_d  = held_q + CW'(req_i.length);
                  left_d  = req_i.length;
                  state_d = CS_WRITE;
                end
              end
              OP_CONSUME: begin
                if (len_x > held_x) begin
                  status_d = ST_SHORT;
                end else begin
                  rp_d   = wrap_ptr(rp_len);
                  held_d = held_q - CW'(req_i.length);
                end
              end
              OP_READ, OP_PEEK: begin
                if (32'(req_i.length) > MAX_RD) begin
                  status_d = ST_BAD_LEN;
                end else if (op_e'(req_i.operation) == OP_READ) begin
                  if (len_x > held_x) begin
                    status_d = ST_SHORT;
                  end else begin
                    pos_d   = rp_q;
                    rp_d    = wrap_ptr(rp_len);
                    held_d  = held_q - CW'(req_i.length);
                    left_d  = req_i.length;
                    n_d     = word_len(req_i.length);
                    state_d = CS_GATHER;
                  end
                end else begin
                  if (peek_end > held_x) begin
                    status_d = ST_SHORT;
                  end else begin
                    pos_d   = wrap_ptr(rp_ofs);
                    left_d  = req_i.length;
                    n_d     = word_len(req_i.length);
                    state_d = CS_GATHER;
                  end
                end
              end
              default: begin
                // unassigned opcodes report ok and touch nothing
                status_d = ST_OK;
              end
            endcase
          end
        end
      end

      CS_WRITE: begin
        mem_we_o = 1'b1;
        wp_d     = wrap_ptr(PW'(wp_q) + PW'(1));
        widx_d   = widx_q + 3'd1;
        left_d   = left_q - LEN_W'(1);
        if (left_q == LEN_W'(1)) begin
          n_d     = '0;
          state_d = CS_EMIT;
        end
      end

      CS_GATHER: begin
        // issue one byte read a cycle, capture each byte in the cycle after its issue
        if (iss_q < n_q) begin
          mem_re_o = 1'b1;
          pos_d    = wrap_ptr(PW'(pos_q) + PW'(1));
          iss_d    = iss_q + BCNT_W'(1);
        end
        if (pend_q) begin
          word_d = word_q | (DATA_W'(mem_rdata_i) << {cap_q[2:0], 3'b000});
          cap_d  = cap_q + BCNT_W'(1);
          if (cap_q + BCNT_W'(1) == n_q) begin
            state_d = CS_EMIT;
          end
        end
      end

      CS_EMIT: begin
        res_push_o = 1'b1;
        if (res_ready_i) begin
          if (left_q == LEN_W'(n_q)) begin
            state_d = CS_IDLE;
          end else begin
            left_d  = left_next;
            n_d     = word_len(left_next);
            word_d  = '0;
            iss_d   = '0;
            cap_d   = '0;
            state_d = CS_GATHER;
          end
        end
      end

      default: begin
        state_d = CS_IDLE;
      end
    endcase
    pend_d = mem_re_o;
  end

  assign mem_waddr_o = wp_q;
  assign mem_wdata_o = wdata_q[{widx_q, 3'b000} +: 8];
  assign mem_raddr_o = pos_q;

  assign fill32 = 32'(held_q);
  assign free32 = CAPACITY - fill32;

  always_comb begin
    res_o.status     = status_q;
    res_o.read_data  = word_q;
    res_o.byte_count = n_q;
    res_o.last       = (left_q == LEN_W'(n_q));
    res_o.fill_count = fill32[FILL_W-1:0];
    res_o.free_space = free32[FILL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      pos_q   <= '0;
      held_q  <= '0;
      left_q  <= '0;
      n_q     <= '0;
      iss_q   <= '0;
      cap_q   <= '0;
      pend_q  <= 1'b0;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      pos_q   <= pos_d;
      held_q  <= held_d;
      left_q  <= left_d;
      n_q     <= n_d;
      iss_q   <= iss_d;
      cap_q   <= cap_d;
      pend_q  <= pend_d;
      widx_q  <= widx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    word_q   <= word_d;
    wdata_q  <= wdata_d;
  end

endmodule

>>> rtl/brb_oreg.sv
// Output register between the sequencer and the result channel.
`timescale 1ns / 1ps
module brb_oreg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          ready_o,
  input  brb_pkg::res_t res_i,
  output logic          valid_o,
  input  logic          take_i,
  output brb_pkg::res_t res_o
);
  import brb_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (push_i && ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> rtl/byte_ring_buffer_peek_consume.sv
// Top level of the byte ring buffer with peek and consume.
`timescale 1ns / 1ps
// Byte ring buffer of CAPACITY bytes held in one byte-wide synchronous RAM.
// Each request carries an operation in s_axis_tuser: write (append up to
// WORD_BYTES bytes, all or nothing), read, peek (at an offset from the oldest
// byte), consume (drop bytes from the tail) or clear (reset head, tail and
// count; contents kept). Reads and peeks of up to min(MAX_REQUEST,
// 8*WORD_BYTES) bytes come out as words of WORD_BYTES bytes, the final word
// flagged by m_axis_tlast; every other request gives one result with tlast
// set. Each result carries status, fill count and free space after the
// request. The sequencer moves one byte per cycle through the RAM, except that
// a read or peek waits between words while the output register cannot take
// one. One request is in work at a time; the next one is taken as soon as the
// previous result sits in the output register. No clearing pass follows
// reset: only bytes that were written are ever read.
module byte_ring_buffer_peek_consume #(
  parameter int unsigned CAPACITY    = 4096,
  parameter int unsigned WORD_BYTES  = 8,
  parameter int unsigned MAX_REQUEST = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // length[6:0], offset[18:7], write_data[82:19], zeros
  input  logic [2:0]  s_axis_tuser,  // operation[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // read_data[63:0], byte_count[67:64],
                                     // fill_count[80:68], free_space[93:81], zeros
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  output logic        m_axis_tlast   // last
);
  import brb_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  req_t          req;
  res_t          ctrl_res, out_res;
  logic          res_push, res_ready;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // unpack the request
  assign req.operation  = s_axis_tuser;
  assign req.length     = s_axis_tdata[6:0];
  assign req.offset     = s_axis_tdata[18:7];
  assign req.write_data = s_axis_tdata[82:19];

  brb_ctrl #(
    .CAPACITY    (CAPACITY),
    .WORD_BYTES  (WORD_BYTES),
    .MAX_REQUEST (MAX_REQUEST),
    .AW          (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_push_o  (res_push),
    .res_ready_i (res_ready),
    .res_o       (ctrl_res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // byte store; the sequencer never reads and writes in the same cycle
  brb_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  brb_oreg u_oreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .ready_o (res_ready),
    .res_i   (ctrl_res),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .res_o   (out_res)
  );

  // pack the result
  assign m_axis_tdata = {2'b00, out_res.free_space, out_res.fill_count,
                         out_res.byte_count, out_res.read_data};
  assign m_axis_tuser = out_res.status;
  assign m_axis_tlast = out_res.last;

endmodule

>>> rtl/brb_checker.sv
// Port-level checks of the byte ring buffer, bound to the top level.
`timescale 1ns / 1ps
`include "byte_ring_buffer_peek_consume_assert.svh"
module brb_checker #(
  parameter int unsigned CAPACITY   = 4096,
  parameter int unsigned WORD_BYTES = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import brb_pkg::*;

  logic [FILL_W-1:0] cnt_sum;
  assign cnt_sum = m_axis_tdata[80:68] + m_axis_tdata[93:81];

  `BRB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
  `BRB_ASSERT_IMP(a_fill_free, clk_i, rst_ni, m_axis_tvalid, cnt_sum == FILL_W'(CAPACITY), "fill count plus free space is not capacity")
  `BRB_ASSERT_IMP(a_refused_empty, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tlast && (m_axis_tdata[67:0] == 68'd0), "refused request carries data")
  `BRB_ASSERT_IMP(a_full_word, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[67:64] == BCNT_W'(WORD_BYTES), "non-final word not full")
  `BRB_ASSERT_NXT(a_one_in_work, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while another is in work")

endmodule

bind byte_ring_buffer_peek_consume brb_checker #(
  .CAPACITY   (CAPACITY),
  .WORD_BYTES (WORD_BYTES)
) u_brb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
